FILE: rtl/core/b64e_pkg.sv
// shared types, constants and alphabet lookup for the base64 stream encoder
package b64e_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;

    // one complete group ready for character generation
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  npad;
        logic        last;
    } grp_t;

    // sextet to ascii, standard alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] c;
        c = 8'h00;
        priority if (s < 6'd26)
            c = 8'h41 + {2'b00, s};
        else if (s < 6'd52)
            c = 8'h61 + {2'b00, s - 6'd26};
        else if (s < 6'd62)
            c = 8'h30 + {2'b00, s - 6'd52};
        else if (s == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

endpackage

FILE: rtl/core/b64e_front.sv
// input side: byte collection and group classification
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       is_final,
    input  logic       q_full,
    output logic       q_push,
    output grp_t       q_wdata
);

    logic [15:0] pend_reg, pend_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        acc;

    assign in_stall = q_full;
    assign acc      = in_valid && !q_full;

    always_comb
    begin
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        q_push        = 1'b0;
        q_wdata.group = {pend_reg, in_byte};
        q_wdata.npad  = PAD_NONE;
        q_wdata.last  = is_final;
        if (acc)
        begin
            if (cnt_reg == 2'd2)
            begin
                q_push    = 1'b1;
                pend_next = 16'h0000;
                cnt_next  = 2'd0;
            end
            else if (!is_final)
            begin
                if (cnt_reg == 2'd0)
                    pend_next = {in_byte, 8'h00};
                else
                    pend_next = {pend_reg[15:8], in_byte};
                cnt_next = cnt_reg + 2'd1;
            end
            else
            begin
                q_push    = 1'b1;
                pend_next = 16'h0000;
                cnt_next  = 2'd0;
                if (cnt_reg == 2'd0)
                begin
                    q_wdata.group = {in_byte, 16'h0000};
                    q_wdata.npad  = PAD_TWO;
                end
                else
                begin
                    q_wdata.group = {pend_reg[15:8], in_byte, 8'h00};
                    q_wdata.npad  = PAD_ONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 16'h0000;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/b64e_queue.sv
// small group queue between front and back
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  grp_t wdata,
    output logic full,
    input  logic pop,
    output logic rvalid,
    output grp_t rdata
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    grp_t          slot_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign rvalid  = (cnt_reg != '0);
    assign rdata   = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        if (do_pop)
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= wdata;
    end

    // occupancy never runs past the depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push while queue full");

    // a pop with nothing held would replay a stale group
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rvalid)
        else $error("pop from empty queue");

    // a lone push raises the count by one next cycle
    a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("queue count missed a push");

endmodule

FILE: rtl/core/b64e_back.sv
// output side: four characters per group, one per cycle while out_stall is low, into an output register
module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  grp_t       q_rdata,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last
);

    logic       busy_reg, busy_next;
    grp_t       cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic [7:0] ch_reg, ch_next;
    logic       lst_reg, lst_next;
    logic       emit, done, is_pad;
    logic [5:0] sext;

    assign emit  = busy_reg && (!ov_reg || !out_stall);
    assign done  = emit && (idx_reg == 2'd3);
    assign q_pop = q_valid && (!busy_reg || done);

    always_comb
    begin
        unique case (idx_reg)
            2'd0: sext = cur_reg.group[23:18];
            2'd1: sext = cur_reg.group[17:12];
            2'd2: sext = cur_reg.group[11:6];
            2'd3: sext = cur_reg.group[5:0];
        endcase
        is_pad = ((idx_reg == 2'd3) && (cur_reg.npad != PAD_NONE))
              || ((idx_reg == 2'd2) && (cur_reg.npad == PAD_TWO));
    end

    always_comb
    begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        ov_next   = ov_reg && out_stall;
        ch_next   = ch_reg;
        lst_next  = lst_reg;
        if (emit)
        begin
            ov_next  = 1'b1;
            ch_next  = is_pad ? PAD_CHAR : b64_char(sext & SEXTET_MASK);
            lst_next = (idx_reg == 2'd3) && cur_reg.last;
            idx_next = idx_reg + 2'd1;
        end
        if (done)
            busy_next = 1'b0;
        if (q_pop)
        begin
            busy_next = 1'b1;
            cur_next  = q_rdata;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ch_reg  <= ch_next;
        lst_reg <= lst_next;
    end

    assign out_valid = ov_reg;
    assign out_char  = ch_reg;
    assign out_last  = lst_reg;

    // a character leaves only from a group in hand
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> busy_reg)
        else $error("emit without a group");

    // a new character appears only after the previous one was taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(ch_reg)))
        else $error("output overwritten while stalled");

endmodule

FILE: rtl/core/base64_stream_encoder_unit.sv
// top level of the base64 stream encoder
//
// input channel: in_valid / in_stall with in_byte and is_final; one raw byte per
// word, is_final marks the last byte of a message.
// output channel: out_valid / out_stall with out_char and out_last; one ascii
// character per word, out_last on the final character of a message.
// every third byte of a group, or a final byte, yields exactly four characters
// (a short final group is padded with '=').
// the byte that closes a group passes through the group queue, the group register
// and the output register before the first character of the group is offered.
// throughput: the character generator produces one character per cycle while
// out_stall is low, and it takes the next group as it emits the last character of
// a group. a byte that does not close a group is taken as long as the group queue
// has room.
// in_stall rises when the group queue is full; out_stall holds the output
// register and the generator, while bytes keep flowing until the queue fills.
// reset clears pending bytes, the queue and the output valid; the first byte
// after reset, or after a final byte, starts a new message.
module base64_stream_encoder_unit
    import b64e_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       is_final,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last
);

    // front to queue
    logic q_push;
    logic q_full;
    grp_t q_wdata;

    // queue to back
    logic q_pop;
    logic q_valid;
    grp_t q_rdata;

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .is_final (is_final),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .out_last  (out_last)
    );

endmodule

FILE: test/base64_stream_encoder_unit_tb.sv
// testbench for the base64 stream encoder: directed table plus random messages, self-checking
module base64_stream_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    // standard alphabet, index 0 in the top byte
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    localparam logic [31:0] NO_PIN      = 32'h0;
    localparam int          STALL_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int          RANDOM_BYTES = 330;
    localparam int          DRAIN_CYCLES = 20;   // extra wait after the final drain

    // one output character as the block presents it
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    // one directed byte; text holds the four characters typed in, or NO_PIN
    typedef struct packed {
        logic [7:0]  b;
        logic        fin;
        logic [31:0] text;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       is_final;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_char;
    logic       out_last;

    // own copy of the encoder state
    logic [15:0] held_bytes;
    logic [1:0]  held_count;

    enc_char_t due_chars [$];  // characters still owed by the block, oldest first
    int        errors;
    int        bytes_sent;
    int        idle_cycles;
    logic      quiet_phase;    // no gaps on either side while set

    // directed part: extremes, each padding case, a full group with and without final
    stim_row_t directed_rows [24] = '{
        '{8'h00, 1'b1, "AA=="},   // lone zero byte right after reset
        '{8'hFF, 1'b1, "/w=="},   // lone all-ones byte
        '{8'h00, 1'b0, NO_PIN},
        '{8'h00, 1'b0, NO_PIN},
        '{8'h00, 1'b0, "AAAA"},   // full group, message goes on
        '{8'hFF, 1'b0, NO_PIN},
        '{8'hFF, 1'b0, NO_PIN},
        '{8'hFF, 1'b1, "////"},   // full group closed by the final byte
        '{8'h00, 1'b0, NO_PIN},
        '{8'hFF, 1'b1, "AP8="},   // final as second byte of a group
        '{8'hFF, 1'b0, NO_PIN},
        '{8'h00, 1'b1, "/wA="},
        '{8'h4D, 1'b0, NO_PIN},
        '{8'h61, 1'b0, NO_PIN},
        '{8'h6E, 1'b1, "TWFu"},
        '{8'h4D, 1'b0, NO_PIN},
        '{8'h61, 1'b1, "TWE="},
        '{8'h4D, 1'b1, "TQ=="},
        '{8'hFB, 1'b0, NO_PIN},
        '{8'hEF, 1'b0, NO_PIN},
        '{8'hBE, 1'b0, "++++"},   // symbol 62 of the alphabet in every position
        '{8'h12, 1'b1, NO_PIN},
        '{8'hA5, 1'b0, NO_PIN},
        '{8'h5A, 1'b1, NO_PIN}
    };

    base64_stream_encoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .is_final  (is_final),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // sextet to ascii through the alphabet string
    function automatic logic [7:0] sextet_ascii(input logic [5:0] s);
        return ALPHABET[8*(63 - int'(s)) +: 8];
    endfunction

    // gap length for either side: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // advance the encoder state by one byte; returns how many characters it yields
    function automatic int encode_byte(input logic [7:0] b, input logic fin,
                                       output enc_char_t [3:0] quad);
        logic [23:0] grp;
        int          n;
        n    = 0;
        grp  = 24'h0;
        quad = '0;
        if (held_count == 2'd2)
        begin
            // third byte closes the group
            grp = {held_bytes, b};
            n   = 4;
            for (int k = 0; k < 4; k++)
                quad[k].ch = sextet_ascii(grp[23-6*k -: 6]);
            quad[3].last = fin;
            held_bytes   = 16'h0;
            held_count   = 2'd0;
        end
        else if (!fin)
        begin
            // group still open, just hold the byte
            if (held_count == 2'd0)
                held_bytes = {b, 8'h00};
            else
                held_bytes[7:0] = b;
            held_count = held_count + 2'd1;
        end
        else
        begin
            // short final group, padded to four
            if (held_count == 2'd0)
                grp = {b, 16'h0};
            else
                grp = {held_bytes[15:8], b, 8'h00};
            n = 4;
            for (int k = 0; k < 4; k++)
                quad[k].ch = sextet_ascii(grp[23-6*k -: 6]);
            if (held_count == 2'd0)
                quad[2].ch = PAD_CHAR;
            quad[3].ch   = PAD_CHAR;
            quad[3].last = 1'b1;
            held_bytes   = 16'h0;
            held_count   = 2'd0;
        end
        return n;
    endfunction

    // offer one byte, wait for it to be taken, then record the characters it owes
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic [31:0] pinned);
        enc_char_t [3:0] quad;
        int              n;
        int              gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            // idle with junk on the payload
            @(negedge clk);
            in_valid <= 1'b0;
            in_byte  <= 8'($urandom);
            is_final <= 1'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        is_final <= fin;
        do
            @(posedge clk);
        while (in_stall);
        n = encode_byte(b, fin, quad);
        for (int k = 0; k < n; k++)
        begin
            // typed-in rows replace the predicted characters
            if (pinned != NO_PIN)
                quad[k].ch = pinned[31-8*k -: 8];
            due_chars = {due_chars, quad[k]};
        end
        bytes_sent++;
    endtask

    // hold the sender off until every owed character has come out
    task automatic drain_output();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_chars.size() != 0)
            @(posedge clk);
    endtask

    // receiver side: random stall runs, with out_stall dropped low after each run
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // output check: each character taken against the oldest one owed
    always @(posedge clk)
    begin
        enc_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_chars.size() == 0)
            begin
                errors++;
                $display("%0t: out_char expected none got %h last %b",
                         $time, out_char, out_last);
            end
            else
            begin
                want = due_chars.pop_front();
                if (out_char !== want.ch)
                begin
                    errors++;
                    $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
                end
                if (out_last !== want.last)
                begin
                    errors++;
                    $display("%0t: out_last expected %b got %b",
                             $time, want.last, out_last);
                end
            end
        end
    end

    // watchdog: too long with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        int         len;
        int         msgs;
        logic [7:0] b;
        errors      = 0;
        bytes_sent  = 0;
        msgs        = 0;
        quiet_phase = 1'b0;
        held_bytes  = 16'h0;
        held_count  = 2'd0;
        in_valid    = 1'b0;
        in_byte     = 8'h00;
        is_final    = 1'b0;
        rst_n       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].fin, directed_rows[i].text);
        drain_output();

        // random messages, mostly short, now and then a long one
        while (bytes_sent < 24 + RANDOM_BYTES)
        begin
            len         = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
            quiet_phase = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 5))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                send_byte(b, i == len - 1, NO_PIN);
            end
            msgs++;
            // let the output side catch up completely now and then
            if (msgs % 20 == 0)
                drain_output();
        end
        quiet_phase = 1'b0;

        drain_output();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_chars.size() != 0)
        begin
            errors++;
            $display("%0t: %0d chars never came out", $time, due_chars.size());
        end
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
